### rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define TSF_ASSERT(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Same-cycle implication.
`define TSF_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TSF_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/tsf_pkg.sv
package tsf_pkg;

   // time and interval widths
   localparam int TIME_W = 32;
   localparam int IVL_W  = 11;
   localparam int CNT_W  = 5;

   // hazard window and blink defaults
   localparam logic [TIME_W-1:0] HAZARD_WINDOW_MS = 32'd500;
   localparam logic [IVL_W-1:0]  DEFAULT_IVL_MS   = 11'd500;
   localparam logic [7:0]        IVL_X10_MIN      = 8'd10;
   localparam logic [7:0]        IVL_X10_MAX      = 8'd200;
   localparam logic [7:0]        IVL_X10_RESET    = 8'd50;
   localparam logic [9:0]        MS_PER_SEC       = 10'd1000;

   // configuration register indexes
   localparam logic [1:0] CSR_FEATURE  = 2'd0;
   localparam logic [1:0] CSR_INTERVAL = 2'd1;
   localparam logic [1:0] CSR_AUTO_OFF = 2'd2;

   // status side codes
   localparam logic [1:0] SIDE_LEFT  = 2'd0;
   localparam logic [1:0] SIDE_RIGHT = 2'd1;
   localparam logic [1:0] SIDE_BOTH  = 2'd2;

   // divider command and response
   typedef struct packed {
      logic              start;
      logic [TIME_W-1:0] dividend;
      logic [IVL_W-1:0]  divisor;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic q_lsb;
   } div_rsp_type;

endpackage

### rtl/turn_signal_hazard_flasher.sv
// Turn signal and hazard flasher.
// req_ carries one item per millisecond tick: the time, the left and right
// request levels and a broadcast flag. rsp_ returns one item per request with
// lamp drives, active flags, clear pulses and the broadcast status.
// csr_ writes feature_present (0), blink_interval_x10 (1), auto_off_seconds (2);
// the user must write them only while the block is idle, which the block itself
// does not enforce; other indexes are ignored. An item is evaluated in the cycle
// after acceptance, then a 32-step serial divider takes now_ms / interval one
// quotient bit per cycle for the blink phase. The divider's done flag moves the
// sequencer to ST_OUT, which loads the result into the output register once that
// register is free. The block takes no new item until the last one's result is
// loaded, as req_tready is high only in ST_IDLE.
// Reset clears all side state and the registers return to their defaults
// (feature off, 500 ms interval, auto shut-off disabled); rsp_tvalid drops.
// If the receiver stalls, the finished result waits in the output register;
// the next item is still accepted and processed, and its result waits until
// the output register is free, holding req_tready low meanwhile.
`include "assert_macros.svh"

module turn_signal_hazard_flasher
   import tsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [31:0] now_ms, [32] left_request, [33] right_request,
   // [34] broadcast_request, [39:35] zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   // rsp_tdata: [0] left_lamp, [1] right_lamp, [2] left_is_on, [3] right_is_on,
   // [4] clear_left, [5] clear_right, [6] status_valid, [7] status_on,
   // [9:8] status_side, [15:10] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_addr,
   input  logic [7:0]  csr_wr_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_DIV, ST_OUT} state_type;

   state_type state_ff;

   // configuration
   logic       feat_ff;
   logic [7:0] ivl_x10_ff;
   logic [7:0] auto_ff;

   // latched item
   logic [TIME_W-1:0] now_ff;
   logic              cur_l_ff, cur_r_ff, bcast_ff;

   // side state
   logic              last_l_ff, last_r_ff, l_act_ff, r_act_ff;
   logic [TIME_W-1:0] l_start_ff, r_start_ff, shut_ff;

   // per-item results waiting for the phase
   logic              clr_l_ff, clr_r_ff, sv_ff, lamp_en_ff, phase_q_ff;

   // output register
   logic              rsp_valid_ff;
   logic [15:0]       rsp_data_ff;

   // evaluation results
   logic              changed, l_up, r_up, l_dn, r_dn, haz, nl, nr;
   logic              near_l, near_r;
   logic              a_last_l, a_last_r, a_l_act, a_r_act;
   logic [TIME_W-1:0] a_l_start, a_r_start, a_shut, s_start;
   logic              a_clr_l, a_clr_r, a_sv, a_lamp_en, off;
   logic [17:0]       auto_ms;

   logic [IVL_W-1:0]  ivl_ms;
   div_cmd_type       div_cmd;
   div_rsp_type       div_rsp;

   logic              out_free, lamp_l, lamp_r, st_on;
   logic [1:0]        st_side;

   // hazard window compares
   assign near_l  = (now_ff - l_start_ff) <= HAZARD_WINDOW_MS;
   assign near_r  = (now_ff - r_start_ff) <= HAZARD_WINDOW_MS;
   assign auto_ms = {10'd0, auto_ff} * {8'd0, MS_PER_SEC};

   // edge resolution and auto shut-off
   always_comb begin
      changed = (cur_l_ff != last_l_ff) || (cur_r_ff != last_r_ff);
      l_up    = cur_l_ff & ~last_l_ff;
      r_up    = cur_r_ff & ~last_r_ff;
      l_dn    = ~cur_l_ff & last_l_ff;
      r_dn    = ~cur_r_ff & last_r_ff;
      haz     = l_act_ff & r_act_ff;
      nl      = l_act_ff;
      nr      = r_act_ff;
      if (l_up && r_up) begin
         nl = 1'b1;
         nr = 1'b1;
      end else if (haz && (l_dn || r_dn)) begin
         nl = 1'b0;
         nr = 1'b0;
      end else if (r_up && l_act_ff && !r_act_ff) begin
         nl = near_l;
         nr = 1'b1;
      end else if (l_up && r_act_ff && !l_act_ff) begin
         nl = 1'b1;
         nr = near_r;
      end else if (l_up) begin
         nl = 1'b1;
      end else if (l_dn) begin
         nl = 1'b0;
      end else if (r_up) begin
         nr = 1'b1;
      end else if (r_dn) begin
         nr = 1'b0;
      end

      a_last_l  = changed ? cur_l_ff : last_l_ff;
      a_last_r  = changed ? cur_r_ff : last_r_ff;
      a_l_start = (changed && nl && !l_act_ff) ? now_ff : l_start_ff;
      a_r_start = (changed && nr && !r_act_ff) ? now_ff : r_start_ff;
      a_clr_l   = changed && !nl && l_act_ff;
      a_clr_r   = changed && !nr && r_act_ff;
      if (a_clr_l) a_last_l = 1'b0;
      if (a_clr_r) a_last_r = 1'b0;
      a_l_act   = changed ? nl : l_act_ff;
      a_r_act   = changed ? nr : r_act_ff;
      a_shut    = (changed && !nl && !nr) ? '0 : shut_ff;
      a_sv      = changed && bcast_ff;
      s_start   = a_shut;
      off       = 1'b0;
      a_lamp_en = 1'b0;

      if (feat_ff && (a_l_act || a_r_act)) begin
         if (auto_ff != '0 && !(a_l_act && a_r_act)) begin
            s_start = (a_shut == '0) ? now_ff : a_shut;
            if ((now_ff - s_start) >= {14'd0, auto_ms}) begin
               off      = 1'b1;
               a_l_act  = 1'b0;
               a_r_act  = 1'b0;
               a_clr_l  = 1'b1;
               a_clr_r  = 1'b1;
               a_last_l = 1'b0;
               a_last_r = 1'b0;
               s_start  = '0;
               a_sv     = 1'b1;
            end
            a_shut = s_start;
         end else begin
            a_shut = '0;
         end
         a_lamp_en = ~off;
      end
   end

   // blink half period in ms
   always_comb begin
      if (ivl_x10_ff >= IVL_X10_MIN && ivl_x10_ff <= IVL_X10_MAX) begin
         ivl_ms = IVL_W'({3'd0, ivl_x10_ff} << 3) + IVL_W'({3'd0, ivl_x10_ff} << 1);
      end else begin
         ivl_ms = DEFAULT_IVL_MS;
      end
   end

   assign div_cmd.start    = (state_ff == ST_EVAL);
   assign div_cmd.dividend = now_ff;
   assign div_cmd.divisor  = ivl_ms;

   tsf_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   // result fields
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign lamp_l   = lamp_en_ff & l_act_ff & ~phase_q_ff;
   assign lamp_r   = lamp_en_ff & r_act_ff & ~phase_q_ff;
   assign st_on    = sv_ff & (l_act_ff | r_act_ff);
   always_comb begin
      if (!sv_ff) st_side = SIDE_LEFT;
      else if (l_act_ff && r_act_ff) st_side = SIDE_BOTH;
      else if (r_act_ff) st_side = SIDE_RIGHT;
      else st_side = SIDE_LEFT;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         feat_ff    <= 1'b0;
         ivl_x10_ff <= IVL_X10_RESET;
         auto_ff    <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_FEATURE:  feat_ff    <= csr_wr_data[0];
            CSR_INTERVAL: ivl_x10_ff <= csr_wr_data;
            CSR_AUTO_OFF: auto_ff    <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // sequencer, side state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_l_ff    <= 1'b0;
         last_r_ff    <= 1'b0;
         l_act_ff     <= 1'b0;
         r_act_ff     <= 1'b0;
         l_start_ff   <= '0;
         r_start_ff   <= '0;
         shut_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new result replaces the one leaving in the same cycle
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) state_ff <= ST_EVAL;
            end
            ST_EVAL: begin
               last_l_ff  <= a_last_l;
               last_r_ff  <= a_last_r;
               l_act_ff   <= a_l_act;
               r_act_ff   <= a_r_act;
               l_start_ff <= a_l_start;
               r_start_ff <= a_r_start;
               shut_ff    <= a_shut;
               state_ff   <= ST_DIV;
            end
            ST_DIV: begin
               if (div_rsp.done) state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_data_ff <= {6'd0, st_side, st_on, sv_ff, clr_r_ff, clr_l_ff,
                                  r_act_ff, l_act_ff, lamp_r, lamp_l};
                  state_ff    <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_tvalid) begin
         now_ff   <= req_tdata[31:0];
         cur_l_ff <= req_tdata[32];
         cur_r_ff <= req_tdata[33];
         bcast_ff <= req_tdata[34];
      end
      if (state_ff == ST_EVAL) begin
         clr_l_ff   <= a_clr_l;
         clr_r_ff   <= a_clr_r;
         sv_ff      <= a_sv;
         lamp_en_ff <= a_lamp_en;
      end
      if (div_rsp.done) phase_q_ff <= div_rsp.q_lsb;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `TSF_ASSERT_IMP(a_clear_left_off, rsp_tvalid && rsp_tdata[4], !rsp_tdata[2],
                   "left cleared but still on")
   `TSF_ASSERT_IMP(a_clear_right_off, rsp_tvalid && rsp_tdata[5], !rsp_tdata[3],
                   "right cleared but still on")
   `TSF_ASSERT_IMP(a_status_quiet, rsp_tvalid && !rsp_tdata[6],
                   !rsp_tdata[7] && rsp_tdata[9:8] == SIDE_LEFT,
                   "status fields set without a broadcast")
   `TSF_ASSERT_IMP(a_lamp_active, rsp_tvalid && rsp_tdata[0], rsp_tdata[2],
                   "left lamp driven while left inactive")
   `TSF_ASSERT_IMP(a_div_in_div, div_rsp.busy, state_ff == ST_DIV,
                   "divider running outside its state")

endmodule

### rtl/tsf_div.sv
`include "assert_macros.svh"

// Restoring divider, one quotient bit per cycle; only the quotient LSB is kept.
module tsf_div
   import tsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_rsp_type rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              q_ff, q_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [IVL_W-1:0]  rem_ff, rem_in;
   logic [IVL_W-1:0]  dvs_ff, dvs_in;
   logic [TIME_W-1:0] num_ff, num_in;
   logic [IVL_W:0]    trial;
   logic              fits;

   // one shift-subtract step
   assign trial = {rem_ff, num_ff[TIME_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      num_in  = num_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = cmd.divisor;
         num_in  = cmd.dividend;
      end else if (busy_ff) begin
         rem_in = fits ? IVL_W'(trial - {1'b0, dvs_ff}) : trial[IVL_W-1:0];
         num_in = {num_ff[TIME_W-2:0], 1'b0};
         q_in   = fits;
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == {CNT_W{1'b1}}) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      num_ff <= num_in;
   end

   assign rsp.busy  = busy_ff;
   assign rsp.done  = done_ff;
   assign rsp.q_lsb = q_ff;

   `TSF_ASSERT_NXT(a_div_start_busy, cmd.start, busy_ff, "divider did not start")
   `TSF_ASSERT_IMP(a_div_done_idle, done_ff, !busy_ff, "divider done while busy")
   `TSF_ASSERT_IMP(a_div_rem_range, busy_ff && dvs_ff != '0, rem_ff < dvs_ff,
                   "divider remainder out of range")

endmodule

### tb/flasher_checker.sv
`timescale 1ns / 100ps

// Watches the request, result and register ports of the flasher, predicts
// every result from the accepted items and compares field by field.
module flasher_checker
   import tsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_addr,
   input  logic [7:0]  csr_wr_data,
   output int          fail_count,
   output int          pending_count
);

   // result item, laid out as on rsp_tdata
   typedef struct packed {
      logic [5:0] pad;
      logic [1:0] status_side;
      logic       status_on;
      logic       status_valid;
      logic       clear_right;
      logic       clear_left;
      logic       right_is_on;
      logic       left_is_on;
      logic       right_lamp;
      logic       left_lamp;
   } lamp_status_type;

   // register copies
   logic        feature_on;
   logic [7:0]  ivl_x10;
   logic [7:0]  auto_off_s;

   // side state
   logic        last_left;
   logic        last_right;
   logic        left_act;
   logic        right_act;
   logic [31:0] left_t0;
   logic [31:0] right_t0;
   logic [31:0] shutoff_t0;

   lamp_status_type lamp_status_q[$];
   lamp_status_type got_status;
   lamp_status_type want_status;
   lamp_status_type next_status;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   task automatic report_mismatch(input string what);
      // keep the log short when the block is badly off
      if (fail_count < 200)
         $display("%0t ns: mismatch: %s", $time, what);
      fail_count++;
   endtask

   // One tick of the flasher: edges, hazard resolution, auto shut-off, blink.
   task automatic predict_flasher(input logic [31:0] now, input logic lreq,
                                  input logic rreq, input logic bcast,
                                  output lamp_status_type res);
      logic        l_up, r_up, l_dn, r_dn;
      logic        nl, nr, hz;
      logic        clr_l, clr_r, stat, lamp_l, lamp_r, off, phase;
      logic [31:0] ivl;
      clr_l  = 1'b0;
      clr_r  = 1'b0;
      stat   = 1'b0;
      lamp_l = 1'b0;
      lamp_r = 1'b0;
      if (lreq != last_left || rreq != last_right) begin
         l_up = lreq && !last_left;
         r_up = rreq && !last_right;
         l_dn = !lreq && last_left;
         r_dn = !rreq && last_right;
         nl   = left_act;
         nr   = right_act;
         hz   = left_act && right_act;
         last_left  = lreq;
         last_right = rreq;
         if (l_up && r_up) begin
            nl = 1'b1; nr = 1'b1;
         end else if (hz && (l_dn || r_dn)) begin
            nl = 1'b0; nr = 1'b0;
         end else if (r_up && left_act && !right_act) begin
            // second side inside the window means hazard, else it takes over
            nr = 1'b1;
            nl = ((now - left_t0) <= HAZARD_WINDOW_MS);
         end else if (l_up && right_act && !left_act) begin
            nl = 1'b1;
            nr = ((now - right_t0) <= HAZARD_WINDOW_MS);
         end else if (l_up) begin
            nl = 1'b1;
         end else if (l_dn) begin
            nl = 1'b0;
         end else if (r_up) begin
            nr = 1'b1;
         end else if (r_dn) begin
            nr = 1'b0;
         end
         if (nl && !left_act) left_t0 = now;
         if (nr && !right_act) right_t0 = now;
         // a cancelled side forgets its level so a held request presses again
         if (!nl && left_act) begin
            clr_l = 1'b1; last_left = 1'b0;
         end
         if (!nr && right_act) begin
            clr_r = 1'b1; last_right = 1'b0;
         end
         left_act  = nl;
         right_act = nr;
         if (!nl && !nr) shutoff_t0 = '0;
         if (bcast) stat = 1'b1;
      end

      if (feature_on && (left_act || right_act)) begin
         off = 1'b0;
         if (auto_off_s != 0 && !(left_act && right_act)) begin
            // start time zero reads as not started
            if (shutoff_t0 == 0) shutoff_t0 = now;
            if ((now - shutoff_t0) >= {24'd0, auto_off_s} * 32'd1000) begin
               left_act   = 1'b0;
               right_act  = 1'b0;
               clr_l      = 1'b1;
               clr_r      = 1'b1;
               last_left  = 1'b0;
               last_right = 1'b0;
               shutoff_t0 = '0;
               stat       = 1'b1;
               off        = 1'b1;
            end
         end else begin
            shutoff_t0 = '0;
         end
         if (!off) begin
            if (ivl_x10 >= IVL_X10_MIN && ivl_x10 <= IVL_X10_MAX)
               ivl = {24'd0, ivl_x10} * 32'd10;
            else
               ivl = 32'd500;
            phase  = ((now / ivl) & 32'd1) == 0;
            lamp_l = left_act && phase;
            lamp_r = right_act && phase;
         end
      end

      res              = '0;
      res.left_lamp    = lamp_l;
      res.right_lamp   = lamp_r;
      res.left_is_on   = left_act;
      res.right_is_on  = right_act;
      res.clear_left   = clr_l;
      res.clear_right  = clr_r;
      res.status_valid = stat;
      res.status_on    = stat && (left_act || right_act);
      if (!stat)
         res.status_side = '0;
      else if (left_act && right_act)
         res.status_side = SIDE_BOTH;
      else if (right_act)
         res.status_side = SIDE_RIGHT;
      else
         res.status_side = SIDE_LEFT;
   endtask

   task automatic compare_status(input lamp_status_type got,
                                 input lamp_status_type want);
      string bad;
      bad = "";
      if (got.left_lamp !== want.left_lamp)
         bad = {bad, $sformatf(" left_lamp %0b/%0b", got.left_lamp, want.left_lamp)};
      if (got.right_lamp !== want.right_lamp)
         bad = {bad, $sformatf(" right_lamp %0b/%0b", got.right_lamp, want.right_lamp)};
      if (got.left_is_on !== want.left_is_on)
         bad = {bad, $sformatf(" left_is_on %0b/%0b", got.left_is_on, want.left_is_on)};
      if (got.right_is_on !== want.right_is_on)
         bad = {bad, $sformatf(" right_is_on %0b/%0b", got.right_is_on,
                               want.right_is_on)};
      if (got.clear_left !== want.clear_left)
         bad = {bad, $sformatf(" clear_left %0b/%0b", got.clear_left, want.clear_left)};
      if (got.clear_right !== want.clear_right)
         bad = {bad, $sformatf(" clear_right %0b/%0b", got.clear_right, want.clear_right)};
      if (got.status_valid !== want.status_valid)
         bad = {bad, $sformatf(" status_valid %0b/%0b", got.status_valid,
                               want.status_valid)};
      if (got.status_on !== want.status_on)
         bad = {bad, $sformatf(" status_on %0b/%0b", got.status_on, want.status_on)};
      if (got.status_side !== want.status_side)
         bad = {bad, $sformatf(" status_side %0d/%0d", got.status_side,
                               want.status_side)};
      if (got.pad !== want.pad)
         bad = {bad, $sformatf(" pad %0h/%0h", got.pad, want.pad)};
      if (bad != "")
         report_mismatch({"result (got/want):", bad});
   endtask

   // register writes, result check, then prediction of the accepted item
   always @(posedge clock) begin
      if (reset) begin
         feature_on = 1'b0;
         ivl_x10    = IVL_X10_RESET;
         auto_off_s = 8'd0;
         last_left  = 1'b0;
         last_right = 1'b0;
         left_act   = 1'b0;
         right_act  = 1'b0;
         left_t0    = '0;
         right_t0   = '0;
         shutoff_t0 = '0;
         lamp_status_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_addr)
               CSR_FEATURE:  feature_on = csr_wr_data[0];
               CSR_INTERVAL: ivl_x10    = csr_wr_data;
               CSR_AUTO_OFF: auto_off_s = csr_wr_data;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got_status = rsp_tdata;
            if (lamp_status_q.size() == 0) begin
               report_mismatch($sformatf("result %h with nothing expected", rsp_tdata));
            end else begin
               want_status = lamp_status_q.pop_front();
               compare_status(got_status, want_status);
            end
         end
         if (req_tvalid && req_tready) begin
            predict_flasher(req_tdata[31:0], req_tdata[32], req_tdata[33],
                            req_tdata[34], next_status);
            lamp_status_q.push_back(next_status);
         end
      end
      pending_count <= lamp_status_q.size();
   end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the flasher; checking lives in flasher_checker.
module tb_top
   import tsf_pkg::*;
;

   localparam int STALL_LIMIT = 4000;

   logic        clock;
   logic        reset;
   // req_tdata: [31:0] now_ms, [32] left_request, [33] right_request,
   // [34] broadcast_request, [39:35] zero
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   // rsp_tdata: [0] left_lamp, [1] right_lamp, [2] left_is_on, [3] right_is_on,
   // [4] clear_left, [5] clear_right, [6] status_valid, [7] status_on,
   // [9:8] status_side, [15:10] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_wr_en;
   logic [1:0]  csr_addr;
   logic [7:0]  csr_wr_data;

   int          fail_count;
   int          pending_count;
   bit          idle_on;
   int          stall_left = 0;
   int          quiet_cycles = 0;
   logic [31:0] now_ms;
   logic        left_lvl;
   logic        right_lvl;

   turn_signal_hazard_flasher i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data)
   );

   flasher_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_wr_en     (csr_wr_en),
      .csr_addr      (csr_addr),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int gap_length();
      if ($urandom_range(0, 9) != 0)
         return $urandom_range(1, 3);
      return $urandom_range(20, 100);
   endfunction

   // result side back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (idle_on && $urandom_range(0, 3) == 0)
            stall_left = gap_length();
      end
   end

   // watchdog: cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic [31:0] now, input logic lreq,
                            input logic rreq, input logic bcast);
      int gap;
      gap = (idle_on && $urandom_range(0, 2) == 0) ? gap_length() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, bcast, rreq, lreq, now};
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   // let every result come out, then a margin past the item latency
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] addr, input logic [7:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_addr    <= addr;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic set_config(input logic feat, input logic [7:0] ivl,
                             input logic [7:0] auto_off);
      drain();
      write_reg(CSR_FEATURE, {7'd0, feat});
      write_reg(CSR_INTERVAL, ivl);
      write_reg(CSR_AUTO_OFF, auto_off);
   endtask

   // random ticks: time mostly creeps, sometimes straddles the hazard window,
   // the shut-off time or jumps anywhere; levels toggle like a driver's stalk
   task automatic run_random(input int count);
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 55)      now_ms = now_ms + $urandom_range(1, 20);
         else if (r < 75) now_ms = now_ms + $urandom_range(100, 900);
         else if (r < 88) now_ms = now_ms + $urandom_range(1000, 6000);
         else if (r < 95) now_ms = now_ms + $urandom_range(10000, 400000);
         else             now_ms = $urandom;
         r = $urandom_range(0, 99);
         if (r < 25) begin
            left_lvl = !left_lvl;
         end else if (r < 50) begin
            right_lvl = !right_lvl;
         end else if (r < 58) begin
            left_lvl  = 1'b1;
            right_lvl = 1'b1;
         end else if (r < 63) begin
            left_lvl  = 1'b0;
            right_lvl = 1'b0;
         end
         send_item(now_ms, left_lvl, right_lvl, 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_wr_en   = 1'b0;
      csr_addr    = CSR_FEATURE;
      csr_wr_data = '0;
      idle_on     = 1'b1;
      now_ms      = '0;
      left_lvl    = 1'b0;
      right_lvl   = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // edges and hazard resolution, longest blink interval
      set_config(1'b1, IVL_X10_MAX, 8'd0);
      send_item(32'd0,    1'b0, 1'b0, 1'b1);
      send_item(32'd10,   1'b1, 1'b0, 1'b1);
      send_item(32'd600,  1'b1, 1'b1, 1'b1);  // late right takes over
      send_item(32'd601,  1'b1, 1'b1, 1'b0);  // held left presses again: hazard
      send_item(32'd700,  1'b0, 1'b1, 1'b1);  // release in hazard clears both
      send_item(32'd701,  1'b1, 1'b1, 1'b1);  // both rise together
      send_item(32'd702,  1'b0, 1'b0, 1'b1);
      send_item(32'd1000, 1'b0, 1'b1, 1'b0);
      send_item(32'd1500, 1'b1, 1'b1, 1'b1);  // exactly at the window edge
      send_item(32'd1600, 1'b1, 1'b0, 1'b1);
      send_item(32'd1601, 1'b0, 1'b0, 1'b0);
      send_item(32'd1700, 1'b1, 1'b0, 1'b0);
      send_item(32'd2201, 1'b1, 1'b1, 1'b0);  // one past the window
      send_item(32'd2300, 1'b1, 1'b0, 1'b0);
      send_item(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1);

      // auto shut-off, timer from time zero, shortest interval
      set_config(1'b1, IVL_X10_MIN, 8'd1);
      send_item(32'd0,    1'b1, 1'b0, 1'b1);
      send_item(32'd5,    1'b1, 1'b0, 1'b0);
      send_item(32'd1004, 1'b1, 1'b0, 1'b0);
      send_item(32'd1005, 1'b1, 1'b0, 1'b1);
      send_item(32'd2000, 1'b0, 1'b0, 1'b0);
      send_item(32'd2001, 1'b1, 1'b0, 1'b0);
      send_item(32'd3001, 1'b1, 1'b1, 1'b1);  // take-over and shut-off together

      now_ms = 32'd3001;
      left_lvl = 1'b1;
      right_lvl = 1'b1;
      for (int p = 0; p < 8; p++) begin
         idle_on = ($urandom_range(0, 3) != 0);
         case (p)
            0: set_config(1'b1, IVL_X10_RESET, 8'd0);
            1: set_config(1'b1, 8'd9, 8'd2);
            2: set_config(1'b0, 8'd201, 8'd1);
            3: set_config(1'b1, 8'd255, 8'd255);
            4: set_config(1'b1, 8'd0, 8'd5);
            5: set_config(1'b1, 8'($urandom_range(10, 200)), 8'($urandom_range(1, 4)));
            6: set_config(1'b0, IVL_X10_MIN, 8'd0);
            default: set_config(1'b1, IVL_X10_MAX, 8'd1);
         endcase
         // some phases run across the time wrap
         if ($urandom_range(0, 2) == 0)
            now_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
         run_random(140);
      end

      drain();
      if (fail_count == 0 && pending_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
